// File: design/lwbc_pkg.sv
package lwbc_pkg;

    localparam int ROUNDS_DEF = 18;
    localparam int ADDR_W     = 4;
    localparam logic [ADDR_W-1:0] ADDR_KEY_HIGH = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_KEY_LOW  = 4'h8;

    typedef logic [15:0] t_word;

    typedef struct packed {
        logic [63:0] kh;
        logic [63:0] kl;
    } t_key;

    typedef logic [6:0] t_kp_tbl [128];
    localparam t_kp_tbl KEY_PERM = '{
        7'd27, 7'd91, 7'd51, 7'd112, 7'd93, 7'd53, 7'd1, 7'd97,
        7'd30, 7'd113, 7'd92, 7'd0, 7'd29, 7'd52, 7'd28, 7'd32,
        7'd99, 7'd127, 7'd3, 7'd15, 7'd70, 7'd50, 7'd121, 7'd86,
        7'd85, 7'd120, 7'd80, 7'd106, 7'd59, 7'd36, 7'd33, 7'd46,
        7'd100, 7'd114, 7'd56, 7'd103, 7'd96, 7'd81, 7'd49, 7'd4,
        7'd16, 7'd117, 7'd118, 7'd7, 7'd19, 7'd71, 7'd39, 7'd10,
        7'd34, 7'd101, 7'd22, 7'd62, 7'd107, 7'd5, 7'd17, 7'd76,
        7'd60, 7'd66, 7'd8, 7'd109, 7'd42, 7'd20, 7'd74, 7'd37,
        7'd40, 7'd72, 7'd115, 7'd44, 7'd47, 7'd94, 7'd54, 7'd11,
        7'd13, 7'd57, 7'd104, 7'd26, 7'd111, 7'd90, 7'd125, 7'd68,
        7'd83, 7'd78, 7'd64, 7'd122, 7'd87, 7'd23, 7'd24, 7'd88,
        7'd123, 7'd63, 7'd77, 7'd82, 7'd67, 7'd110, 7'd43, 7'd124,
        7'd89, 7'd25, 7'd12, 7'd108, 7'd75, 7'd61, 7'd73, 7'd41,
        7'd65, 7'd21, 7'd38, 7'd9, 7'd18, 7'd6, 7'd116, 7'd48,
        7'd95, 7'd55, 7'd45, 7'd102, 7'd35, 7'd58, 7'd105, 7'd79,
        7'd84, 7'd119, 7'd69, 7'd14, 7'd2, 7'd126, 7'd98, 7'd31};

    typedef logic [3:0] t_s4_tbl [16];
    localparam t_s4_tbl S4 = '{4'h0, 4'hF, 4'hE, 4'h5, 4'hD, 4'h3, 4'h6, 4'hC,
                               4'hB, 4'h9, 4'hA, 4'h8, 4'h7, 4'h4, 4'h2, 4'h1};

    typedef logic [7:0] t_s8_tbl [256];
    localparam t_s8_tbl S8 = '{
        8'h52, 8'h5B, 8'h72, 8'h7B, 8'h5D, 8'hD4, 8'h7F, 8'h76,
        8'h53, 8'h5A, 8'h73, 8'h7A, 8'hD5, 8'h5C, 8'h77, 8'h7E,
        8'h84, 8'h0B, 8'h66, 8'h6B, 8'h0D, 8'h02, 8'h6F, 8'h62,
        8'h03, 8'h0C, 8'h63, 8'h6E, 8'h85, 8'h0A, 8'h67, 8'h6A,
        8'hF0, 8'h79, 8'hD0, 8'h59, 8'h7D, 8'hF4, 8'h5F, 8'h56,
        8'hF1, 8'h78, 8'hD1, 8'h58, 8'hF5, 8'h7C, 8'h57, 8'h5E,
        8'hE4, 8'h69, 8'h06, 8'h09, 8'h6D, 8'hE0, 8'h0F, 8'h80,
        8'hE1, 8'h6C, 8'h81, 8'h0E, 8'hE5, 8'h68, 8'h07, 8'h08,
        8'hA4, 8'h29, 8'h26, 8'h2B, 8'h2D, 8'hA0, 8'h2F, 8'h22,
        8'hA1, 8'h2C, 8'h23, 8'h2E, 8'hA5, 8'h28, 8'h27, 8'h2A,
        8'hB0, 8'h39, 8'h32, 8'h3B, 8'h3D, 8'hB4, 8'h3F, 8'h36,
        8'hB1, 8'h38, 8'h33, 8'h3A, 8'hB5, 8'h3C, 8'h37, 8'h3E,
        8'hC4, 8'h4B, 8'h46, 8'h49, 8'h4D, 8'h42, 8'h4F, 8'hC0,
        8'h43, 8'h4C, 8'hC1, 8'h4E, 8'hC5, 8'h4A, 8'h47, 8'h48,
        8'h12, 8'h1B, 8'h90, 8'h19, 8'h1D, 8'h94, 8'h1F, 8'h16,
        8'h13, 8'h1A, 8'h91, 8'h18, 8'h95, 8'h1C, 8'h17, 8'h1E,
        8'h8C, 8'h8B, 8'hEE, 8'hEB, 8'h8D, 8'h8A, 8'hEF, 8'hEA,
        8'h83, 8'h04, 8'hE3, 8'hE6, 8'h05, 8'h82, 8'hE7, 8'hE2,
        8'hDA, 8'hDB, 8'hFA, 8'hFB, 8'hDD, 8'hDC, 8'hFF, 8'hFE,
        8'hD3, 8'hD2, 8'hF3, 8'hF2, 8'h55, 8'h54, 8'hF7, 8'hF6,
        8'hEC, 8'hE9, 8'h8E, 8'h89, 8'hED, 8'hE8, 8'h8F, 8'h88,
        8'h61, 8'h64, 8'h01, 8'h86, 8'h65, 8'h60, 8'h87, 8'h00,
        8'hF8, 8'hF9, 8'hD8, 8'hD9, 8'hFD, 8'hFC, 8'hDF, 8'hDE,
        8'h71, 8'h70, 8'h51, 8'h50, 8'h75, 8'h74, 8'hD7, 8'hD6,
        8'hAC, 8'hA9, 8'hAE, 8'hAB, 8'hAD, 8'hA8, 8'hAF, 8'hAA,
        8'h21, 8'h24, 8'hA3, 8'hA6, 8'h25, 8'h20, 8'hA7, 8'hA2,
        8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBD, 8'hBC, 8'hBF, 8'hBE,
        8'h31, 8'h30, 8'hB3, 8'hB2, 8'h35, 8'h34, 8'hB7, 8'hB6,
        8'hCC, 8'hCB, 8'hCE, 8'hC9, 8'hCD, 8'hCA, 8'hCF, 8'hC8,
        8'hC3, 8'h44, 8'h41, 8'hC6, 8'h45, 8'hC2, 8'hC7, 8'h40,
        8'h9A, 8'h9B, 8'h98, 8'h99, 8'h9D, 8'h9C, 8'h9F, 8'h9E,
        8'h93, 8'h92, 8'h11, 8'h10, 8'h15, 8'h14, 8'h97, 8'h96};

    typedef logic [3:0] t_p16_tbl [16];
    localparam t_p16_tbl PERM_A = '{4'd10, 4'd4, 4'd5, 4'd11, 4'd1, 4'd2, 4'd9, 4'd12,
                                    4'd13, 4'd6, 4'd0, 4'd3, 4'd7, 4'd8, 4'd15, 4'd14};
    localparam t_p16_tbl PERM_B = '{4'd10, 4'd7, 4'd4, 4'd2, 4'd3, 4'd12, 4'd5, 4'd15,
                                    4'd11, 4'd1, 4'd6, 4'd8, 4'd14, 4'd9, 4'd13, 4'd0};

    // bit index 0 is the msb
    function automatic t_word bitperm16(input t_word v, input t_p16_tbl tbl);
        t_word o;
        o = '0;
        for (int i = 0; i < 16; i++) begin
            o[15 - tbl[i]] = v[15 - i];
        end
        return o;
    endfunction

    function automatic t_word sub4x4(input t_word v);
        return {S4[v[15:12]], S4[v[11:8]], S4[v[7:4]], S4[v[3:0]]};
    endfunction

    function automatic t_word mix16(input t_word v);
        logic [7:0] a, b;
        a = v[15:8];
        b = v[7:0];
        return {a ^ {a[1:0], a[7:2]} ^ {a[5:0], a[7:6]},
                {b[2:0], b[7:3]} ^ {b[3:0], b[7:4]} ^ {b[6:0], b[7]}};
    endfunction

    function automatic t_word rotl5(input t_word v);
        return {v[10:0], v[15:11]};
    endfunction

    function automatic t_word g2(input t_word a, input t_word b);
        t_word x;
        x = a ^ b;
        return bitperm16({S8[x[15:8]], S8[x[7:0]]}, PERM_B);
    endfunction

    function automatic logic [63:0] ks_half(input logic [63:0] v);
        logic [63:0] o;
        o = v;
        o[63:60] = S4[v[63:60]];
        o[59:56] = S4[v[59:56]];
        o[31:28] = S4[v[31:28]];
        o[27:24] = S4[v[27:24]];
        o = o ^ (64'd59 << 40) ^ (64'd77 << 8);
        return o;
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
        return (v << r) | (v >> (64 - r));
    endfunction

    // one schedule step, round index mod 3 picks the halves and rotations
    function automatic t_key key_step(input t_key k, input int m);
        logic [127:0] kb, ka;
        logic [31:0] q0, q1, q2, q3;
        logic [63:0] ha, hb;
        t_key o;
        kb = {k.kh, k.kl};
        ka = '0;
        for (int i = 0; i < 128; i++) begin
            ka[127 - KEY_PERM[i]] = kb[127 - i];
        end
        q0 = ka[127:96];
        q1 = ka[95:64];
        q2 = ka[63:32];
        q3 = ka[31:0];
        if (m == 0) begin
            ha = {q0, q1};
            hb = {q2, q3};
            o.kh = rotl64(ks_half(ha), 21);
            o.kl = rotl64(ks_half(hb), 13);
        end else if (m == 1) begin
            ha = {q0, q2};
            hb = {q1, q3};
            o.kh = rotl64(ks_half(ha), 7);
            o.kl = rotl64(ks_half(hb), 35);
        end else begin
            ha = {q0, q3};
            hb = {q1, q2};
            o.kh = rotl64(ks_half(ha), 63);
            o.kl = rotl64(ks_half(hb), 49);
        end
        return o;
    endfunction

endpackage

// File: design/lwbc_round.sv
// one round stage: data round plus next key, registered, with stall
module lwbc_round import lwbc_pkg::*; #(
    parameter int RIDX = 0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_data,
    input  t_key        i_key,
    output logic        o_valid,
    output logic [63:0] o_data,
    output t_key        o_key,
    input  logic        i_stall
);
    logic        r_valid;
    logic [63:0] r_data;
    t_key        r_key;
    t_key        n_key;
    logic [63:0] n_data;
    logic        w_adv;

    always_comb begin
        t_word w0, w1, w2, w3, k0, k1, f0, f1, f2, f3;
        n_key = key_step(i_key, RIDX % 3);
        k0 = n_key.kh[63:48];
        k1 = n_key.kh[47:32];
        w0 = i_data[63:48];
        w1 = i_data[47:32];
        w2 = i_data[31:16];
        w3 = i_data[15:0];
        f0 = mix16(sub4x4(bitperm16(w0 ^ k0, PERM_A)));
        f3 = bitperm16(sub4x4(mix16(w3)), PERM_A) ^ k1;
        if ((RIDX % 2) == 0) begin
            f1 = g2(rotl5(f0), w3);
            f2 = {f1[6:0], 9'd0};
            n_data = {f1 ^ w1, f0, f3, f2 ^ w2};
        end else begin
            f2 = g2(f0, rotl5(w3));
            f1 = {f2[6:0], 9'd0};
            n_data = {f3, f2 ^ w2, f1 ^ w1, f0};
        end
    end

    assign w_adv = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_data <= n_data;
            r_key  <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_key   = r_key;
endmodule

// File: design/lwbc_regs.sv
// key registers behind the apb port
module lwbc_regs import lwbc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output t_key              o_key
);
    t_key r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ADDR_KEY_HIGH: r_key.kh <= pwdata;
                ADDR_KEY_LOW:  r_key.kl <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_KEY_HIGH: prdata = r_key.kh;
            ADDR_KEY_LOW:  prdata = r_key.kl;
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_key  = r_key;
endmodule

// File: design/lightweight_block_cipher_64_encrypt.sv
// 64-bit block encryption under a 128-bit key, fully unrolled pipeline.
// input channel: i_valid / o_stall with i_plaintext; a transfer happens
// at a clock edge with i_valid high and o_stall low.
// output channel: o_valid / i_stall with o_ciphertext, same rule.
// key: two 64-bit registers on the apb port, key_high at 0x0 and key_low at
// 0x8; the user must write them only while the pipeline is empty (the block
// does not enforce it). One register stage per round (round function and
// key schedule step together). throughput: one block per cycle when unstalled,
// set by the single stage per round. A receiver stall holds the unbroken run
// of occupied stages at the output end; stages behind an empty one still
// fill, so bubbles are squeezed out. o_stall is the first stage's hold.
// reset (synchronous, active low) empties the pipeline and clears the key.
module lightweight_block_cipher_64_encrypt import lwbc_pkg::*; #(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [63:0]       i_plaintext,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [63:0]       o_ciphertext,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);
    t_key        w_cfg_key;
    logic        w_valid [ROUNDS+1];
    logic [63:0] w_data  [ROUNDS+1];
    t_key        w_key   [ROUNDS+1];
    logic        w_stall [ROUNDS+1];

    lwbc_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_key(w_cfg_key)
    );

    assign w_valid[0]      = i_valid;
    assign w_data[0]       = i_plaintext;
    assign w_key[0]        = w_cfg_key;
    assign w_stall[ROUNDS] = i_stall;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
        lwbc_round #(.RIDX(g)) u_round (
            .i_clk, .i_rst_n,
            .i_valid(w_valid[g]), .i_data(w_data[g]), .i_key(w_key[g]),
            .o_valid(w_valid[g+1]), .o_data(w_data[g+1]), .o_key(w_key[g+1]),
            .i_stall(w_stall[g+1])
        );
        // stage g holds, blocking its input, when it is full and its output is held
        assign w_stall[g] = w_valid[g+1] && w_stall[g+1];
    end

    assign o_stall      = w_stall[0];
    assign o_valid      = w_valid[ROUNDS];
    assign o_ciphertext = w_data[ROUNDS];
endmodule

// File: design/lwbc_checker.sv
module lwbc_checker import lwbc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_ciphertext
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ciphertext))
        else $error("result dropped or changed under stall");

    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input held while output is free");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input held with empty output stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
endmodule

bind lightweight_block_cipher_64_encrypt lwbc_checker u_chk (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall, .o_ciphertext
);
